/* rtl/psc_pkg.sv */
// shared types and constants for the plane slice point classifier
`default_nettype none

package psc_pkg;

  localparam int COORD_W = 16;
  localparam int NORM_W  = 16;
  localparam int OFFS_W  = 17;
  localparam int RAD_W   = 16;
  localparam int CFG_W   = 17;
  localparam int ADDR_W  = 3;
  localparam int IDX_W   = 6;
  localparam int ZONE_W  = 2;
  localparam int QBITS   = 14;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int PROJ_W  = PROD_W + 2;
  localparam int SQ_W    = 2 * COORD_W - 1;
  localparam int R2_W    = 2 * COORD_W;
  // offset accumulator holds first_offset plus 64 steps
  localparam int OFF_W   = 24;
  localparam int DIFF_W  = OFF_W + QBITS + 1;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 56;

  localparam logic [DIFF_W-1:0] TOL_Q = DIFF_W'(5 * (1 << QBITS));

  localparam logic [ADDR_W-1:0] CFG_NORMAL_X      = 3'd0;
  localparam logic [ADDR_W-1:0] CFG_NORMAL_Y      = 3'd1;
  localparam logic [ADDR_W-1:0] CFG_NORMAL_Z      = 3'd2;
  localparam logic [ADDR_W-1:0] CFG_FIRST_OFFSET  = 3'd3;
  localparam logic [ADDR_W-1:0] CFG_LAST_OFFSET   = 3'd4;
  localparam logic [ADDR_W-1:0] CFG_SLICE_STEP    = 3'd5;
  localparam logic [ADDR_W-1:0] CFG_SAFE_RADIUS   = 3'd6;
  localparam logic [ADDR_W-1:0] CFG_DANGER_RADIUS = 3'd7;

  localparam logic [ZONE_W-1:0] ZONE_NEAR = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_MID  = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_FAR  = 2'd2;

  typedef struct packed {
    logic load_point;
    logic start_scan;
    logic advance;
    logic capture;
    logic push;
    logic push_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic normal_zero;
    logic scan_done;
    logic match;
    logic pend_valid;
    logic out_free;
  } ctl_stat_t;

endpackage

`default_nettype wire

/* rtl/psc_datapath.sv */
// datapath: config registers, projection and range, slice scan, result registers
`default_nettype none

module psc_datapath
  import psc_pkg::*;
#(
  parameter int MAX_SLICES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic [IN_W-1:0]   s_tdata,
  input  wire ctl_cmd_t          cmd,
  output ctl_stat_t              stat,
  output logic [OUT_W-1:0]       m_tdata,
  output logic                   m_tvalid,
  output logic                   m_tlast,
  input  wire logic              m_tready
);

  localparam int KW = $clog2(MAX_SLICES + 1);

  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic signed [OFFS_W-1:0] first_offset, last_offset;
  logic [RAD_W-1:0]         slice_step, safe_radius, danger_radius;

  logic signed [COORD_W-1:0] in_x, in_y, in_z;
  logic signed [COORD_W-1:0] pt_x, pt_y, pt_z;
  logic signed [PROD_W-1:0]  mul_px, mul_py, mul_pz, mul_sx, mul_sy, mul_sz;
  logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
  logic [SQ_W-1:0]           sq_x, sq_y, sq_z;
  logic [R2_W-1:0]           safe2, danger2, r2_sum;
  logic signed [PROJ_W-1:0]  proj;
  logic [ZONE_W-1:0]         zone;

  logic signed [OFF_W-1:0]   off;
  logic [KW-1:0]             k;
  logic signed [DIFF_W-1:0]  diff;
  logic                      below_win;

  logic                      pend_valid;
  logic [COORD_W-1:0]        pend_x, pend_y, pend_z;
  logic [IDX_W-1:0]          pend_idx;
  logic [ZONE_W-1:0]         pend_zone;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x      <= '0;
      normal_y      <= '0;
      normal_z      <= '0;
      first_offset  <= '0;
      last_offset   <= '0;
      slice_step    <= RAD_W'(50);
      safe_radius   <= RAD_W'(1300);
      danger_radius <= RAD_W'(800);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NORMAL_X:      normal_x      <= cfg_data[NORM_W-1:0];
        CFG_NORMAL_Y:      normal_y      <= cfg_data[NORM_W-1:0];
        CFG_NORMAL_Z:      normal_z      <= cfg_data[NORM_W-1:0];
        CFG_FIRST_OFFSET:  first_offset  <= cfg_data[OFFS_W-1:0];
        CFG_LAST_OFFSET:   last_offset   <= cfg_data[OFFS_W-1:0];
        CFG_SLICE_STEP:    slice_step    <= cfg_data[RAD_W-1:0];
        CFG_SAFE_RADIUS:   safe_radius   <= cfg_data[RAD_W-1:0];
        CFG_DANGER_RADIUS: danger_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_x = s_tdata[15:0];
  assign in_y = s_tdata[31:16];
  assign in_z = s_tdata[47:32];

  always_comb begin
    mul_px = PROD_W'(in_x) * PROD_W'(normal_x);
    mul_py = PROD_W'(in_y) * PROD_W'(normal_y);
    mul_pz = PROD_W'(in_z) * PROD_W'(normal_z);
    mul_sx = PROD_W'(in_x) * PROD_W'(in_x);
    mul_sy = PROD_W'(in_y) * PROD_W'(in_y);
    mul_sz = PROD_W'(in_z) * PROD_W'(in_z);
  end

  // products taken straight off the input word
  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      pt_x    <= in_x;
      pt_y    <= in_y;
      pt_z    <= in_z;
      prod_x  <= mul_px;
      prod_y  <= mul_py;
      prod_z  <= mul_pz;
      sq_x    <= mul_sx[SQ_W-1:0];
      sq_y    <= mul_sy[SQ_W-1:0];
      sq_z    <= mul_sz[SQ_W-1:0];
      safe2   <= R2_W'(safe_radius) * R2_W'(safe_radius);
      danger2 <= R2_W'(danger_radius) * R2_W'(danger_radius);
    end
  end

  assign r2_sum = R2_W'(sq_x) + R2_W'(sq_y) + R2_W'(sq_z);

  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      proj <= PROJ_W'(prod_x) + PROJ_W'(prod_y) + PROJ_W'(prod_z);
      if (r2_sum >= safe2) begin
        zone <= ZONE_FAR;
      end else if (r2_sum >= danger2) begin
        zone <= ZONE_MID;
      end else begin
        zone <= ZONE_NEAR;
      end
    end
  end

  // slice walk: one offset per cycle while advance is given; held while a match waits on a busy output register
  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      off <= OFF_W'(first_offset);
      k   <= '0;
    end else if (cmd.advance) begin
      off <= off + OFF_W'($signed({1'b0, slice_step}));
      k   <= k + KW'(1);
    end
  end

  assign diff      = DIFF_W'(proj) - DIFF_W'($signed({off, {QBITS{1'b0}}}));
  // offsets only grow, so once the projection sits below a window the scan is over
  assign below_win = diff < -$signed(TOL_Q);

  assign stat.match       = !below_win && (diff <= $signed(TOL_Q));
  assign stat.scan_done   = (k == KW'(MAX_SLICES)) || (off > OFF_W'(last_offset)) || below_win;
  assign stat.normal_zero = (normal_x == '0) && (normal_y == '0) && (normal_z == '0);
  assign stat.pend_valid  = pend_valid;
  assign stat.out_free    = !m_tvalid || m_tready;

  // one match held back until we know whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.capture) begin
      pend_valid <= 1'b1;
    end else if (cmd.push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pend_x    <= pt_x;
      pend_y    <= pt_y;
      pend_z    <= pt_z;
      pend_idx  <= IDX_W'(k);
      pend_zone <= zone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= {pend_zone, pend_idx, pend_z, pend_y, pend_x};
      m_tlast <= cmd.push_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/psc_ctrl.sv */
// controller: sequences point load, sum, slice scan and final flush
`default_nettype none

module psc_ctrl
  import psc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire ctl_stat_t stat,
  output ctl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SUM   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_point = 1'b1;
          if (!stat.normal_zero) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd.start_scan = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_FLUSH;
        end else if (!(stat.match && stat.pend_valid && !stat.out_free)) begin
          cmd.advance = 1'b1;
          cmd.capture = stat.match;
          cmd.push    = stat.match && stat.pend_valid;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> stat.out_free)
    else $error("result pushed into an occupied output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.capture && stat.pend_valid |-> cmd.push)
    else $error("held match overwritten before it was sent");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.pend_valid)
    else $error("new point taken while a match is still held");

  a_zero_normal: assert property (@(posedge clk) disable iff (rst)
    cmd.load_point && stat.normal_zero |=> s_tready)
    else $error("zero normal did not return to idle");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("not idle after reset");

endmodule

`default_nettype wire

/* rtl/plane_slice_point_classifier.sv */
// top level of the plane slice point classifier
// Takes one 3-D point per input word, projects it onto the configured Q1.14 normal
// and emits one word per slice whose offset lies within 5 mm of the projection,
// carrying the point, the slice index and a near/mid/far zone from squared range.
// The slice offsets are walked one per cycle by a single comparator, pausing while
// a held match waits for the output register to drain: the walk starts at slice 0
// and stops after last_offset, after MAX_SLICES slices, or once the offsets pass the
// projection window. A point is not accepted until all words of the previous point
// have left the held-match register.
// A zero normal takes the point and emits nothing.
`default_nettype none

module plane_slice_point_classifier
  import psc_pkg::*;
#(
  parameter int MAX_SLICES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_W-1:0]   s_tdata,   // pos_x, pos_y, pos_z
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata,   // out_x, out_y, out_z, slice_index, zone
  output logic                   m_tlast    // last_of_point
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psc_datapath #(
    .MAX_SLICES (MAX_SLICES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tlast  (m_tlast),
    .m_tready (m_tready)
  );

endmodule

`default_nettype wire
